// File: rtl/core/acia_pkg.sv
// Shared types and constants for the ACIA serial port core.
package acia_pkg;

  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 4;

  localparam int DATA_W = 8;
  localparam int RX_W = DATA_W + 1;
  localparam int RX_MARK_BIT = DATA_W;

  localparam logic [1:0] CTRL_TX_IRQ_MODE = 2'b01;
  localparam logic [1:0] CTRL_RTS_MODE = 2'b10;
  localparam int CTRL_MODE_LO = 5;
  localparam int CTRL_RX_IRQ_BIT = 7;

  localparam int STAT_RDRF_BIT = 0;
  localparam int STAT_TDRE_BIT = 1;
  localparam int STAT_DCD_BIT = 2;
  localparam int STAT_CTS_BIT = 3;
  localparam int STAT_IRQ_BIT = 7;

  typedef enum logic [2:0] {
    OP_BUS_WRITE,
    OP_BUS_READ,
    OP_RX_BYTE,
    OP_DCD,
    OP_CTS,
    OP_RX_CLEAR,
    OP_RX_TICK,
    OP_TX_TICK
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } rxq_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rxq_stat_t;

endpackage

// File: rtl/core/acia_if.sv
// Valid/ready channels for ACIA event words and result words.
interface acia_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic       reg_select;
  logic [7:0] data;
  logic       level;

  modport source (output valid, output op, output reg_select, output data, output level,
                  input ready);
  modport sink (input valid, input op, input reg_select, input data, input level,
                output ready);
endinterface

interface acia_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;
  logic       rts;
  logic       tx_valid;
  logic [7:0] tx_data;

  modport source (output valid, output read_data, output irq, output rts, output tx_valid,
                  output tx_data, input ready);
  modport sink (input valid, input read_data, input irq, input rts, input tx_valid,
                input tx_data, output ready);
endinterface

// File: rtl/core/acia_rx_queue.sv
// Receive queue: memory with registered read of the head entry and write bypass.
module acia_rx_queue import acia_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  rxq_ctl_t        ctl,
  input  logic [RX_W-1:0] wdata,
  output rxq_stat_t       stat,
  output logic [RX_W-1:0] head_data
);

  localparam int AW = $clog2(RX_DEPTH);
  localparam int CW = $clog2(RX_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [RX_W-1:0] mem [RX_DEPTH];
  logic [RX_W-1:0] rd_q;
  logic [RX_W-1:0] byp_data;
  logic            byp;
  logic [AW-1:0]   head;
  logic [AW-1:0]   head_next;
  logic [AW-1:0]   tail;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [SW-1:0]   tail_sum;
  logic            wr_en;

  assign stat.full = (count == CW'(RX_DEPTH));
  assign stat.empty = (count == '0);
  assign tail_sum = SW'(head) + SW'(count);
  assign tail = (tail_sum >= SW'(RX_DEPTH)) ? AW'(tail_sum - SW'(RX_DEPTH)) : AW'(tail_sum);
  assign wr_en = ctl.push && !stat.full;
  assign head_data = byp ? byp_data : rd_q;

  always_comb begin
    head_next = head;
    count_next = count;
    priority if (ctl.clear) begin
      head_next = '0;
      count_next = '0;
    end else if (wr_en) begin
      count_next = count + 1'b1;
    end else if (ctl.pop && !stat.empty) begin
      head_next = (head == AW'(RX_DEPTH - 1)) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= wdata;
    end
    rd_q <= mem[head_next];
    byp_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      byp <= 1'b0;
    end else begin
      head <= head_next;
      count <= count_next;
      byp <= wr_en && (tail == head_next);
    end
  end

endmodule

// File: rtl/core/acia_serial_port_core.sv
// ACIA serial port core: bus registers, transmit queue and receive queue.
// One event word is taken per clock unless the output stalls, and each gives exactly
// one result word; an event is registered on entry, processed combinationally and its
// result held in an output register, so back-to-back events run at one word per
// cycle when rsp.ready holds high. The receive queue is a RX_DEPTH-entry memory whose
// head entry is read ahead into a register; the transmit queue is TX_DEPTH registers.
module acia_serial_port_core import acia_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  acia_item_if.sink    req,
  acia_result_if.source rsp
);

  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int TX_SW = TX_CW + 1;

  logic              s1_valid;
  op_t               s1_op;
  logic              s1_sel;
  logic [DATA_W-1:0] s1_data;
  logic              s1_level;
  logic              advance;
  logic              fire;

  logic [7:0]        ctrl;
  logic [7:0]        ctrl_next;
  logic              rdrf, rdrf_next;
  logic              tdre, tdre_next;
  logic              dcd, dcd_next;
  logic              cts, cts_next;
  logic [DATA_W-1:0] holding, holding_next;
  logic              irq_cur, irq_next;

  logic [DATA_W-1:0] tx_mem [TX_DEPTH];
  logic [TX_AW-1:0]  tx_head, tx_head_next, tx_tail;
  logic [TX_CW-1:0]  tx_count, tx_count_next;
  logic [TX_SW-1:0]  tx_sum;
  logic              tx_push;

  rxq_ctl_t          rxq_ctl;
  rxq_stat_t         rxq_stat;
  logic [RX_W-1:0]   rxq_wdata;
  logic [RX_W-1:0]   rxq_head;

  logic [DATA_W-1:0] rd_next;
  logic              txv_next;
  logic [DATA_W-1:0] txd_next;
  logic [DATA_W-1:0] status;

  logic              out_valid;
  logic [DATA_W-1:0] out_read_data;
  logic              out_irq;
  logic              out_rts;
  logic              out_tx_valid;
  logic [DATA_W-1:0] out_tx_data;

  assign advance = !out_valid || rsp.ready;
  assign fire = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  assign rsp.valid = out_valid;
  assign rsp.read_data = out_read_data;
  assign rsp.irq = out_irq;
  assign rsp.rts = out_rts;
  assign rsp.tx_valid = out_tx_valid;
  assign rsp.tx_data = out_tx_data;

  assign tx_sum = TX_SW'(tx_head) + TX_SW'(tx_count);
  assign tx_tail = (tx_sum >= TX_SW'(TX_DEPTH)) ? TX_AW'(tx_sum - TX_SW'(TX_DEPTH))
                                                : TX_AW'(tx_sum);

  assign irq_cur = ((ctrl[CTRL_MODE_LO +: 2] == CTRL_TX_IRQ_MODE) && tdre && !cts) ||
                   (ctrl[CTRL_RX_IRQ_BIT] && rdrf);
  assign irq_next = ((ctrl_next[CTRL_MODE_LO +: 2] == CTRL_TX_IRQ_MODE) && tdre_next &&
                     !cts_next) || (ctrl_next[CTRL_RX_IRQ_BIT] && rdrf_next);

  always_comb begin
    status = '0;
    status[STAT_RDRF_BIT] = rdrf;
    status[STAT_TDRE_BIT] = tdre;
    status[STAT_DCD_BIT] = dcd;
    status[STAT_CTS_BIT] = cts;
    status[STAT_IRQ_BIT] = irq_cur;
  end

  always_comb begin
    ctrl_next = ctrl;
    rdrf_next = rdrf;
    tdre_next = tdre;
    dcd_next = dcd;
    cts_next = cts;
    holding_next = holding;
    tx_head_next = tx_head;
    tx_count_next = tx_count;
    tx_push = 1'b0;
    rxq_ctl = '0;
    rxq_wdata = {1'b0, s1_data};
    rd_next = '0;
    txv_next = 1'b0;
    txd_next = '0;
    if (fire) begin
      unique case (s1_op)
        OP_BUS_WRITE: begin
          if (s1_sel) begin
            if (tdre && (tx_count < TX_CW'(TX_DEPTH))) begin
              tx_push = 1'b1;
              tx_count_next = tx_count + 1'b1;
              if (tx_count_next == TX_CW'(TX_DEPTH)) begin
                tdre_next = 1'b0;
              end
            end
          end else begin
            ctrl_next = s1_data;
          end
        end
        OP_BUS_READ: begin
          if (s1_sel) begin
            rdrf_next = 1'b0;
            rd_next = holding;
          end else begin
            rd_next = status;
          end
        end
        OP_RX_BYTE: begin
          rxq_ctl.push = 1'b1;
        end
        OP_DCD: begin
          rxq_ctl.push = s1_level;
          rxq_wdata = '0;
          rxq_wdata[RX_MARK_BIT] = 1'b1;
        end
        OP_CTS: begin
          cts_next = s1_level;
        end
        OP_RX_CLEAR: begin
          rxq_ctl.clear = 1'b1;
        end
        OP_RX_TICK: begin
          if (!rdrf && !rxq_stat.empty) begin
            rxq_ctl.pop = 1'b1;
            if (rxq_head[RX_MARK_BIT]) begin
              dcd_next = 1'b1;
            end else begin
              holding_next = rxq_head[DATA_W-1:0];
              dcd_next = 1'b0;
              rdrf_next = 1'b1;
            end
          end
        end
        OP_TX_TICK: begin
          if (!cts && (tx_count != '0)) begin
            txv_next = 1'b1;
            txd_next = tx_mem[tx_head];
            tx_head_next = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
            tx_count_next = tx_count - 1'b1;
            tdre_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  acia_rx_queue #(
    .RX_DEPTH(RX_DEPTH)
  ) u_rx_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rxq_ctl),
    .wdata     (rxq_wdata),
    .stat      (rxq_stat),
    .head_data (rxq_head)
  );

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op <= op_t'(req.op);
      s1_sel <= req.reg_select;
      s1_data <= req.data;
      s1_level <= req.level;
    end
    if (tx_push) begin
      tx_mem[tx_tail] <= s1_data;
    end
    if (fire) begin
      out_read_data <= rd_next;
      out_irq <= irq_next;
      out_rts <= (ctrl_next[CTRL_MODE_LO +: 2] == CTRL_RTS_MODE);
      out_tx_valid <= txv_next;
      out_tx_data <= txd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      ctrl <= '0;
      rdrf <= 1'b0;
      tdre <= 1'b1;
      dcd <= 1'b0;
      cts <= 1'b0;
      holding <= '0;
      tx_head <= '0;
      tx_count <= '0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      ctrl <= ctrl_next;
      rdrf <= rdrf_next;
      tdre <= tdre_next;
      dcd <= dcd_next;
      cts <= cts_next;
      holding <= holding_next;
      tx_head <= tx_head_next;
      tx_count <= tx_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_tx_count_bound: assert property (@(posedge clk) disable iff (rst)
    tx_count <= TX_CW'(TX_DEPTH))
    else $error("transmit count beyond depth");

  a_tdre_full: assert property (@(posedge clk) disable iff (rst)
    !tdre |-> (tx_count == TX_CW'(TX_DEPTH)))
    else $error("TDRE clear with room in transmit queue");

  a_rx_pop_ok: assert property (@(posedge clk) disable iff (rst)
    rxq_ctl.pop |-> (!rdrf && !rxq_stat.empty))
    else $error("receive pop with RDRF set or empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(ctrl) && $stable(tx_count)))
    else $error("state advanced while result stalled");
`endif

endmodule

// File: verif/tb_acia_serial_port_core.sv
// Self-checking testbench for the ACIA serial port core: directed and random event words.
module tb_acia_serial_port_core;
  import acia_pkg::*;

  localparam int IDLE_PCT = 35;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       rts;
    logic       tx_valid;
    logic [7:0] tx_data;
  } port_result_t;

  logic clk = 1'b0;
  logic rst;

  acia_item_if   req_if ();
  acia_result_if rsp_if ();

  acia_serial_port_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted port state
  logic [7:0]      ctrl_byte = '0;
  logic            rdrf = 1'b0;
  logic            tdre = 1'b1;
  logic            dcd_flag = 1'b0;
  logic            cts_flag = 1'b0;
  logic [7:0]      rx_hold = '0;
  logic [RX_W-1:0] rx_fifo[$];
  logic [7:0]      tx_fifo[$];

  port_result_t pending_port_results[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           stall_count = 0;
  bit           req_idle = 1'b1;
  bit           rsp_idle = 1'b0;
  bit           rsp_hold = 1'b0;
  int           hold_left = 0;
  bit           hold_taken = 1'b0;

  function automatic logic irq_level();
    return ((ctrl_byte[CTRL_MODE_LO +: 2] == CTRL_TX_IRQ_MODE) && tdre && !cts_flag) ||
           (ctrl_byte[CTRL_RX_IRQ_BIT] && rdrf);
  endfunction

  function automatic port_result_t predict_port_event(op_t op, logic sel, logic [7:0] data,
                                                      logic level);
    port_result_t    r;
    logic [RX_W-1:0] entry;
    r = '0;
    case (op)
      OP_BUS_WRITE: begin
        if (!sel) begin
          ctrl_byte = data;
        end else if (tdre && tx_fifo.size() < TX_DEPTH_DEF) begin
          tx_fifo.push_back(data);
          if (tx_fifo.size() == TX_DEPTH_DEF) tdre = 1'b0;
        end
      end
      OP_BUS_READ: begin
        if (sel) begin
          rdrf = 1'b0;
          r.read_data = rx_hold;
        end else begin
          r.read_data[STAT_RDRF_BIT] = rdrf;
          r.read_data[STAT_TDRE_BIT] = tdre;
          r.read_data[STAT_DCD_BIT] = dcd_flag;
          r.read_data[STAT_CTS_BIT] = cts_flag;
          r.read_data[STAT_IRQ_BIT] = irq_level();
        end
      end
      OP_RX_BYTE: begin
        if (rx_fifo.size() < RX_DEPTH_DEF) rx_fifo.push_back({1'b0, data});
      end
      OP_DCD: begin
        if (level && rx_fifo.size() < RX_DEPTH_DEF) rx_fifo.push_back({1'b1, 8'h00});
      end
      OP_CTS: cts_flag = level;
      OP_RX_CLEAR: rx_fifo.delete();
      OP_RX_TICK: begin
        if (!rdrf && rx_fifo.size() > 0) begin
          entry = rx_fifo.pop_front();
          if (entry[RX_MARK_BIT]) begin
            dcd_flag = 1'b1;
          end else begin
            rx_hold = entry[DATA_W-1:0];
            dcd_flag = 1'b0;
            rdrf = 1'b1;
          end
        end
      end
      default: begin
        if (!cts_flag && tx_fifo.size() > 0) begin
          r.tx_data = tx_fifo.pop_front();
          r.tx_valid = 1'b1;
          tdre = 1'b1;
        end
      end
    endcase
    r.irq = irq_level();
    r.rts = (ctrl_byte[CTRL_MODE_LO +: 2] == CTRL_RTS_MODE);
    return r;
  endfunction

  task automatic send_event(op_t op, logic sel, logic [7:0] data, logic level);
    if (req_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.reg_select <= sel;
    req_if.data <= data;
    req_if.level <= level;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_port_results.push_back(predict_port_event(op, sel, data, level));
    items_sent++;
  endtask

  task automatic send_random_event(bit flood);
    int   pick;
    op_t  op;
    logic lvl;
    pick = $urandom_range(99);
    if (flood && pick < 70) begin
      op = (pick < 60) ? OP_RX_BYTE : OP_DCD;
    end else begin
      pick = $urandom_range(99);
      if (pick < 25) op = OP_BUS_WRITE;
      else if (pick < 45) op = OP_BUS_READ;
      else if (pick < 58) op = OP_RX_BYTE;
      else if (pick < 64) op = OP_DCD;
      else if (pick < 71) op = OP_CTS;
      else if (pick < 74) op = OP_RX_CLEAR;
      else if (pick < 86) op = OP_RX_TICK;
      else op = OP_TX_TICK;
    end
    lvl = (op == OP_CTS) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
    send_event(op, 1'($urandom_range(1)), 8'($urandom_range(255)), lvl);
  endtask

  task automatic send_random_run(int count, bit flood);
    int stop;
    int n;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case (flood ? 9 : $urandom_range(9))
        0, 1: begin
          send_event(OP_RX_BYTE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
          send_event(OP_RX_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
          send_event(OP_BUS_READ, 1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
          send_event(OP_BUS_READ, 1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        2: begin
          n = $urandom_range(1, TX_DEPTH_DEF + 1);
          repeat (n) send_event(OP_BUS_WRITE, 1'b1, 8'($urandom_range(255)),
                                1'($urandom_range(1)));
          repeat (n) send_event(OP_TX_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                                1'($urandom_range(1)));
        end
        default: send_random_event(flood);
      endcase
    end
  endtask

  task automatic test_reset_state();
    send_event(OP_BUS_READ, 1'b0, 8'h00, 1'b0);
    send_event(OP_BUS_READ, 1'b1, 8'hFF, 1'b1);
    send_event(OP_TX_TICK, 1'b0, 8'h00, 1'b0);
    send_event(OP_RX_TICK, 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_control_modes();
    send_event(OP_BUS_WRITE, 1'b0, 8'h20, 1'b0);
    send_event(OP_BUS_READ, 1'b0, 8'h00, 1'b0);
    send_event(OP_BUS_WRITE, 1'b0, 8'h40, 1'b1);
    send_event(OP_BUS_WRITE, 1'b0, 8'h60, 1'b0);
    send_event(OP_BUS_WRITE, 1'b0, 8'hFF, 1'b1);
    send_event(OP_BUS_WRITE, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_tx_queue();
    send_event(OP_BUS_WRITE, 1'b1, 8'h00, 1'b0);
    send_event(OP_BUS_WRITE, 1'b1, 8'hFF, 1'b1);
    send_event(OP_BUS_WRITE, 1'b1, 8'hA5, 1'b0);
    send_event(OP_BUS_WRITE, 1'b1, 8'h5A, 1'b1);
    send_event(OP_BUS_WRITE, 1'b1, 8'h3C, 1'b0);
    send_event(OP_CTS, 1'b0, 8'h00, 1'b1);
    send_event(OP_TX_TICK, 1'b0, 8'h00, 1'b0);
    send_event(OP_CTS, 1'b1, 8'hFF, 1'b0);
    repeat (TX_DEPTH_DEF + 1) send_event(OP_TX_TICK, 1'b1, 8'h00, 1'b1);
  endtask

  task automatic test_rx_queue();
    send_event(OP_DCD, 1'b0, 8'h00, 1'b0);
    send_event(OP_RX_BYTE, 1'b0, 8'hFF, 1'b0);
    send_event(OP_DCD, 1'b1, 8'h00, 1'b1);
    send_event(OP_RX_BYTE, 1'b1, 8'h00, 1'b1);
    send_event(OP_BUS_WRITE, 1'b0, 8'h80, 1'b0);
    send_event(OP_RX_TICK, 1'b0, 8'h00, 1'b0);
    send_event(OP_RX_TICK, 1'b0, 8'h00, 1'b0);
    send_event(OP_BUS_READ, 1'b0, 8'h00, 1'b0);
    send_event(OP_BUS_READ, 1'b1, 8'h00, 1'b0);
    send_event(OP_RX_TICK, 1'b0, 8'h00, 1'b0);
    send_event(OP_RX_TICK, 1'b0, 8'h00, 1'b0);
    send_event(OP_RX_BYTE, 1'b0, 8'h55, 1'b0);
    send_event(OP_RX_CLEAR, 1'b1, 8'hFF, 1'b1);
    send_event(OP_RX_TICK, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_random_mixed(int count);
    req_idle = 1'b1;
    rsp_idle <= 1'b1;
    send_random_run(count, 1'b0);
  endtask

  task automatic test_no_idle(int count);
    req_idle = 1'b0;
    rsp_idle <= 1'b0;
    send_random_run(count, 1'b0);
  endtask

  task automatic test_rx_flood(int count);
    req_idle = 1'b1;
    rsp_idle <= 1'b1;
    send_random_run(count, 1'b1);
  endtask

  task automatic test_output_stall(int count);
    req_idle = 1'b0;
    rsp_hold <= 1'b1;
    send_random_run(count, 1'b0);
    rsp_hold <= 1'b0;
  endtask

  task automatic test_sender_pause(int count);
    req_idle = 1'b1;
    rsp_idle <= 1'b1;
    send_random_run(count, 1'b0);
    req_if.valid <= 1'b0;
    while (pending_port_results.size() != 0) @(posedge clk);
    send_random_run(count, 1'b0);
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rsp_hold) begin
        hold_taken = 1'b0;
      end else if (!hold_taken) begin
        hold_taken = 1'b1;
        hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(rsp_idle && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    port_result_t got;
    port_result_t want;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.read_data = rsp_if.read_data;
      got.irq = rsp_if.irq;
      got.rts = rsp_if.rts;
      got.tx_valid = rsp_if.tx_valid;
      got.tx_data = rsp_if.tx_data;
      if (pending_port_results.size() == 0) begin
        if (error_count < 10) $display("unexpected result word %h", got);
        error_count++;
      end else begin
        want = pending_port_results.pop_front();
        if (got !== want) begin
          if (error_count < 10) begin
            $display("mismatch exp/act: read_data %h/%h irq %b/%b rts %b/%b",
                     want.read_data, got.read_data, want.irq, got.irq, want.rts, got.rts,
                     " tx_valid %b/%b tx_data %h/%h",
                     want.tx_valid, got.tx_valid, want.tx_data, got.tx_data);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("tb_acia_serial_port_core NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.op <= OP_BUS_WRITE;
    req_if.reg_select <= 1'b0;
    req_if.data <= '0;
    req_if.level <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    rsp_idle <= 1'b1;
    test_reset_state();
    test_control_modes();
    test_tx_queue();
    test_rx_queue();
    test_random_mixed(600);
    test_no_idle(250);
    test_rx_flood(200);
    test_output_stall(60);
    test_sender_pause(100);
    test_random_mixed(150);
    req_if.valid <= 1'b0;
    while (pending_port_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_acia_serial_port_core OK");
    end else begin
      $display("tb_acia_serial_port_core NOT OK");
    end
    $finish;
  end

endmodule

// File: acia_serial_port_core.f
rtl/core/acia_pkg.sv
rtl/core/acia_if.sv
rtl/core/acia_rx_queue.sv
rtl/core/acia_serial_port_core.sv
verif/tb_acia_serial_port_core.sv
